>>> hw/rtl/sha512_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 package
// Round constants, initial hash values and the rotate helper function.
// ----------------------------------------------------------------------------
package sha512_pkg;

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [4:0]  PAD_WORDS = 5'd14;   // 112 bytes

    localparam logic [63:0] IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
        64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
        64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
        64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
        64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
        64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
        64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
        64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
        64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
        64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
        64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
        64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
        64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
        64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
        64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
        64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
        64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
        64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
        64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
        64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    typedef logic [63:0] word_t;

    function automatic word_t ror64(input word_t v, input int k);
        ror64 = (v >> k) | (v << (64 - k));
    endfunction

endpackage

>>> hw/rtl/sha512_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 round unit
// One compression round and one schedule step; shared across all 80 rounds.
// ----------------------------------------------------------------------------
module sha512_round (
    input  sha512_pkg::word_t vars_in [8],
    input  sha512_pkg::word_t sched_in [16],
    input  logic [6:0]        round,
    output sha512_pkg::word_t vars_out [8],
    output sha512_pkg::word_t w_out
);
    import sha512_pkg::*;

    word_t a15, a2, sg0, sg1, s0, s1, ch, mj, t1, t2;
    logic [3:0] r4;

    always_comb
    begin
        r4  = round[3:0];
        a15 = sched_in[4'(r4 + 4'd1)];
        a2  = sched_in[4'(r4 + 4'd14)];
        sg0 = ror64(a15, 1) ^ ror64(a15, 8) ^ (a15 >> 7);
        sg1 = ror64(a2, 19) ^ ror64(a2, 61) ^ (a2 >> 6);
        if (round < 7'd16)
            w_out = sched_in[r4];
        else
            w_out = sched_in[r4] + sg0 + sched_in[4'(r4 + 4'd9)] + sg1;
        s1 = ror64(vars_in[4], 14) ^ ror64(vars_in[4], 18) ^ ror64(vars_in[4], 41);
        ch = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
        t1 = vars_in[7] + s1 + ch + ROUND_K[round] + w_out;
        s0 = ror64(vars_in[0], 28) ^ ror64(vars_in[0], 34) ^ ror64(vars_in[0], 39);
        mj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
           ^ (vars_in[1] & vars_in[2]);
        t2 = s0 + mj;
        vars_out[7] = vars_in[6];
        vars_out[6] = vars_in[5];
        vars_out[5] = vars_in[4];
        vars_out[4] = vars_in[3] + t1;
        vars_out[3] = vars_in[2];
        vars_out[2] = vars_in[1];
        vars_out[1] = vars_in[0];
        vars_out[0] = t1 + t2;
    end

endmodule

>>> hw/rtl/sha512_hash_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 hash engine
// Buffers message words into blocks, compresses, pads and emits the digest.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries message beats: tdata = message_word, tuser = valid_bytes
//   (bits 3:0), tlast = end_of_message. A word is taken whenever tready is
//   high; the sixteenth word of a block starts the shared round unit, which
//   runs one round per cycle through the 80 rounds and then folds into the
//   hash state, with s_axis_tready low meanwhile.
//   On tlast the engine inserts the pad word, zero words and the two length
//   words itself, one per cycle, compressing one or two more blocks, then
//   presents eight digest beats on m_axis: tdata = digest_word, tuser =
//   word_index (bits 2:0), tlast = last_word. Each digest beat holds while
//   m_axis_tready is low; input stays stalled until the last one is taken.
//   Reset loads the initial hash values and clears counts; the block is
//   ready as soon as reset is released.
// ----------------------------------------------------------------------------
module sha512_hash_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  sha512_pkg::word_t       s_axis_tdata,   // message_word
    input  logic [3:0]              s_axis_tuser,   // valid_bytes
    input  logic                    s_axis_tlast,   // end_of_message
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output sha512_pkg::word_t       m_axis_tdata,   // digest_word
    output logic [2:0]              m_axis_tuser,   // word_index
    output logic                    m_axis_tlast    // last_word
);
    import sha512_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_ROUND, ST_FOLD, ST_PAD, ST_EMIT} state_t;
    typedef enum logic [1:0] {PAD_ZERO, PAD_LEN_HI, PAD_LEN_LO, PAD_LEAD} pad_t;

    state_t     state_reg;
    word_t      hash_reg [8];
    word_t      vars_reg [8];
    word_t      sched_reg [16];
    word_t      count_reg;
    logic [3:0] fill_reg;
    logic [6:0] round_reg;
    logic [2:0] emit_reg;
    logic       final_reg;   // padding under way
    pad_t       pad_reg;     // what the next pad cycle writes
    logic       two_blk_reg; // pad spills into an extra block

    word_t      vars_next [8];
    word_t      w_next;
    word_t      pad_word;
    word_t      count_next;
    logic [3:0] nb;
    logic [3:0] nb_sat;
    logic       take;

    sha512_round u_round (
        .vars_in  (vars_reg),
        .sched_in (sched_reg),
        .round    (round_reg),
        .vars_out (vars_next),
        .w_out    (w_next)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign take          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (state_reg == ST_EMIT);
    assign m_axis_tdata  = hash_reg[emit_reg];
    assign m_axis_tuser  = emit_reg;
    assign m_axis_tlast  = (emit_reg == 3'd7);

    always_comb
    begin
        nb_sat   = (s_axis_tuser > 4'd8) ? 4'd8 : s_axis_tuser;
        nb       = s_axis_tlast ? nb_sat : 4'd8;
        pad_word = s_axis_tdata;
        if (s_axis_tlast && nb_sat != 4'd8)
        begin
            pad_word = (nb_sat == 4'd0) ? 64'd0
                     : s_axis_tdata & ~((64'd1 << (7'd64 - {nb_sat, 3'd0})) - 64'd1);
            pad_word = pad_word | (64'(PAD_BYTE) << (6'd56 - {nb_sat[2:0], 3'd0}));
        end
        count_next = count_reg + 64'(nb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            hash_reg    <= IV;
            count_reg   <= '0;
            fill_reg    <= '0;
            round_reg   <= '0;
            emit_reg    <= '0;
            final_reg   <= 1'b0;
            pad_reg     <= PAD_ZERO;
            two_blk_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        count_reg <= count_next;
                        if (!s_axis_tlast)
                        begin
                            sched_reg[fill_reg] <= s_axis_tdata;
                            fill_reg <= fill_reg + 4'd1;
                            if (fill_reg == 4'd15)
                            begin
                                state_reg <= ST_ROUND;
                                vars_reg  <= hash_reg;
                                round_reg <= '0;
                            end
                        end
                        else if (nb_sat == 4'd8)
                        begin
                            final_reg <= 1'b1;
                            // full final word: pad byte goes in the next word
                            two_blk_reg <= (fill_reg >= 4'd13);
                            sched_reg[fill_reg] <= s_axis_tdata;
                            if (fill_reg == 4'd15)
                            begin
                                // pad byte opens the next block
                                fill_reg  <= 4'd0;
                                pad_reg   <= PAD_LEAD;
                                state_reg <= ST_ROUND;
                                vars_reg  <= hash_reg;
                                round_reg <= '0;
                            end
                            else
                            begin
                                sched_reg[fill_reg + 4'd1] <= {PAD_BYTE, 56'd0};
                                fill_reg <= fill_reg + 4'd2;
                                pad_reg  <= (fill_reg == PAD_WORDS[3:0] - 4'd2)
                                          ? PAD_LEN_HI : PAD_ZERO;
                                if (fill_reg == 4'd14)
                                begin
                                    state_reg <= ST_ROUND;
                                    vars_reg  <= hash_reg;
                                    round_reg <= '0;
                                end
                                else
                                    state_reg <= ST_PAD;
                            end
                        end
                        else
                        begin
                            final_reg   <= 1'b1;
                            two_blk_reg <= (fill_reg >= 4'd14);
                            sched_reg[fill_reg] <= pad_word;
                            fill_reg <= fill_reg + 4'd1;
                            pad_reg  <= (fill_reg == PAD_WORDS[3:0] - 4'd1)
                                      ? PAD_LEN_HI : PAD_ZERO;
                            if (fill_reg == 4'd15)
                            begin
                                state_reg <= ST_ROUND;
                                vars_reg  <= hash_reg;
                                round_reg <= '0;
                            end
                            else
                                state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    // insert one pad, zero or length word per cycle
                    unique case (pad_reg)
                        PAD_LEAD:
                        begin
                            sched_reg[fill_reg] <= {PAD_BYTE, 56'd0};
                            pad_reg <= PAD_ZERO;
                        end
                        PAD_ZERO:
                        begin
                            sched_reg[fill_reg] <= 64'd0;
                            if (!two_blk_reg && fill_reg == PAD_WORDS[3:0] - 4'd1)
                                pad_reg <= PAD_LEN_HI;
                        end
                        PAD_LEN_HI:
                        begin
                            sched_reg[fill_reg] <= {61'd0, count_reg[63:61]};
                            pad_reg <= PAD_LEN_LO;
                        end
                        default:
                            sched_reg[fill_reg] <= {count_reg[60:0], 3'd0};
                    endcase
                    fill_reg <= fill_reg + 4'd1;
                    if (fill_reg == 4'd15)
                    begin
                        state_reg <= ST_ROUND;
                        vars_reg  <= hash_reg;
                        round_reg <= '0;
                    end
                end
                ST_ROUND:
                begin
                    vars_reg <= vars_next;
                    sched_reg[round_reg[3:0]] <= w_next;
                    if (round_reg == 7'd79)
                    begin
                        round_reg <= '0;
                        state_reg <= ST_FOLD;
                    end
                    else
                        round_reg <= round_reg + 7'd1;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + vars_reg[i];
                    if (!final_reg)
                        state_reg <= ST_IDLE;
                    else if (two_blk_reg)
                    begin
                        // first pass fills to 15 then length needs extra block
                        two_blk_reg <= 1'b0;
                        state_reg   <= ST_PAD;
                    end
                    else if (fill_reg == 4'd0 && pad_reg == PAD_LEN_LO)
                        state_reg <= ST_EMIT;
                    else
                        state_reg <= ST_PAD;
                end
                ST_EMIT:
                begin
                    if (m_axis_tready)
                    begin
                        emit_reg <= emit_reg + 3'd1;
                        if (emit_reg == 3'd7)
                        begin
                            state_reg <= ST_IDLE;
                            hash_reg  <= IV;
                            count_reg <= '0;
                            fill_reg  <= '0;
                            final_reg <= 1'b0;
                            pad_reg   <= PAD_ZERO;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
